/* hw/rtl/srm_pkg.sv */
// Shared types and constants for the serial register access master.
`default_nettype none

package srm_pkg;

  // Command codes carried by each request.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } command_t;

  // Phases of one serial bit.
  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned INDEX_W    = 5;

  // One request: a tick, or a tick that starts an access.
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] bank;
    logic [2:0] sub_address;
    logic [7:0] write_data;
    logic       sdo;
  } request_t;

  // One result: pin levels and status after the tick.
  typedef struct packed {
    logic       cs;
    logic       sck;
    logic       sdi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/srm_tick_engine.sv */
// Frame state and per-tick waveform logic of the serial register access master.
`default_nettype none

module srm_tick_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire srm_pkg::request_t item,
  output srm_pkg::result_t      res
);
  import srm_pkg::*;

  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [INDEX_W-1:0]    bit_index, bit_index_next;
  phase_t                bit_phase, bit_phase_next;
  logic                  active, active_next;
  logic                  is_read, is_read_next;
  logic [7:0]            read_shift, read_shift_next;

  logic start;
  logic load;
  logic frame_bit;

  // Next state and pin levels for one tick.
  always_comb begin
    start = (item.command == CMD_WRITE) || (item.command == CMD_READ);
    load  = start && !active;

    frame_shift_next = frame_shift;
    bit_index_next   = bit_index;
    bit_phase_next   = bit_phase;
    active_next      = active;
    is_read_next     = is_read;
    read_shift_next  = read_shift;

    // A start while idle loads the frame; this same tick is the first setup.
    if (load) begin
      is_read_next     = (item.command == CMD_READ);
      frame_shift_next = {(is_read_next ? 8'h00 : item.write_data), item.bank,
                          item.sub_address, is_read_next};
      bit_index_next   = '0;
      bit_phase_next   = PH_SETUP;
      read_shift_next  = '0;
      active_next      = 1'b1;
    end

    res           = '0;
    res.rejected  = start && active;
    frame_bit     = frame_shift_next[bit_index_next[3:0]];

    if (active_next) begin
      if (bit_index_next[INDEX_W-1]) begin
        // Chip-select drop tick after the last bit.
        res.done_res   = 1'b1;
        res.read_data  = is_read_next ? read_shift_next : 8'h00;
        active_next    = 1'b0;
        bit_index_next = '0;
        bit_phase_next = PH_SETUP;
      end else begin
        res.cs = 1'b1;
        case (bit_phase_next)
          PH_SETUP: begin
            res.sdi = frame_bit;
            // Data bits are sampled at setup, first sample lands in bit 0.
            if (is_read_next && bit_index_next[3]) begin
              read_shift_next = {item.sdo, read_shift_next[7:1]};
            end
            bit_phase_next = PH_HIGH;
          end
          PH_HIGH: begin
            res.sck        = 1'b1;
            res.sdi        = frame_bit;
            bit_phase_next = PH_LOW;
          end
          default: begin
            bit_phase_next = PH_SETUP;
            bit_index_next = bit_index_next + 1'b1;
          end
        endcase
      end
    end

    res.busy_res = active_next;
  end

  // State advances only when a tick is handed on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bit_index   <= '0;
      bit_phase   <= PH_SETUP;
      active      <= 1'b0;
      is_read     <= 1'b0;
      read_shift  <= '0;
    end else if (step) begin
      frame_shift <= frame_shift_next;
      bit_index   <= bit_index_next;
      bit_phase   <= bit_phase_next;
      active      <= active_next;
      is_read     <= is_read_next;
      read_shift  <= read_shift_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/serial_register_access_master_core.sv */
// Top level of the serial register access master: input and result registers.
// Usage:
//   Each request is one tick of the serial waveform. Its command is a plain
//   tick, or a tick that starts a write or read access of a 16-bit frame.
//   Every request gives exactly one result with the cs, sck and sdi levels
//   after that tick, plus busy, done, read data and rejected flags.
//   Both channels use valid and stall; a transfer happens when valid is high
//   and stall is low at a rising edge of clk.
//   A request passes from the input register to the result register.
//   Throughput: one request per cycle while the result side does not stall;
//   the frame state is updated in the same cycle the request moves from the
//   input register to the result register. When the result side stalls, the
//   result register holds and the input register takes a request only if it
//   is empty; once it holds one, request_stall rises.
//   Reset (rst, synchronous) empties both registers and returns the frame
//   state to idle with chip select low.
`default_nettype none

module serial_register_access_master_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              request_valid,
  output logic                   request_stall,
  input  wire srm_pkg::request_t request,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output srm_pkg::result_t       result
);
  import srm_pkg::*;

  logic     hold_valid;
  request_t hold;
  logic     out_free;
  logic     advance;
  result_t  step_res;

  // The result register can load when it is empty or being drained.
  assign out_free      = !result_valid || !result_stall;
  assign advance       = hold_valid && out_free;
  assign request_stall = hold_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!request_stall) begin
      hold_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!request_stall && request_valid) begin
      hold <= request;
    end
  end

  srm_tick_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (hold),
    .res  (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  // A finished frame always leaves chip select low and the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> !result.cs && !result.busy_res)
    else $error("done result with chip select or busy still high");

  // A start is only rejected while a frame is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rejected |-> result.busy_res || result.done_res)
    else $error("start rejected while idle");

  // The serial clock only pulses inside a frame.
  a_sck_in_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sck |-> result.cs && result.busy_res)
    else $error("serial clock high outside a frame");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

/* verif/tb_serial_register_access_master_core.sv */
// Testbench for the serial register access master: random stimulus with per-tick prediction.
`timescale 1ns / 100ps

module tb_serial_register_access_master_core;
  import srm_pkg::*;

  // Command value with no access of its own; the block treats it as a tick.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned DATA_FIRST_BIT = 8;
  localparam int unsigned RANDOM_ITEMS = 1500;
  // Near the end of the run both sides stop idling.
  localparam int unsigned TAIL_ITEMS = 150;
  // How the device data out pin behaves during a generated frame.
  localparam int SDO_LOW = 0;
  localparam int SDO_HIGH = 1;
  localparam int SDO_RANDOM = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  request_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  serial_register_access_master_core dut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #6 clk = ~clk;

  request_t pending_requests[$];
  result_t expected_pins[$];
  int unsigned error_count = 0;
  logic request_taken = 1'b0;
  logic quiet_tail = 1'b0;
  int send_gap = 0;
  int hold_left = 0;

  // Frame state of the predicted master.
  logic [15:0] frame_bits = '0;
  logic [INDEX_W-1:0] bit_count = '0;
  phase_t bit_phase = PH_SETUP;
  logic frame_active = 1'b0;
  logic frame_is_read = 1'b0;
  logic [7:0] read_byte = '0;

  // Advance the predicted master by one tick and return the pin levels and flags.
  function automatic result_t step_frame(input request_t req);
    result_t res;
    logic line_bit;
    res = '0;
    if (req.command == CMD_WRITE || req.command == CMD_READ) begin
      if (frame_active) begin
        res.rejected = 1'b1;
      end else begin
        frame_is_read = (req.command == CMD_READ);
        frame_bits = {frame_is_read ? 8'h00 : req.write_data, req.bank, req.sub_address,
                      frame_is_read};
        bit_count = '0;
        bit_phase = PH_SETUP;
        read_byte = '0;
        frame_active = 1'b1;
      end
    end
    if (frame_active) begin
      if (bit_count >= FRAME_BITS) begin
        // Chip select drops on the tick after the last bit.
        res.done_res = 1'b1;
        res.read_data = frame_is_read ? read_byte : 8'h00;
        frame_active = 1'b0;
        bit_count = '0;
        bit_phase = PH_SETUP;
      end else begin
        line_bit = frame_bits[bit_count[3:0]];
        res.cs = 1'b1;
        case (bit_phase)
          PH_SETUP: begin
            res.sdi = line_bit;
            // Read data arrives first bit first, so it shifts in from the top.
            if (frame_is_read && bit_count >= DATA_FIRST_BIT) begin
              read_byte = {req.sdo, read_byte[7:1]};
            end
            bit_phase = PH_HIGH;
          end
          PH_HIGH: begin
            res.sck = 1'b1;
            res.sdi = line_bit;
            bit_phase = PH_LOW;
          end
          default: begin
            bit_phase = PH_SETUP;
            bit_count = bit_count + 1'b1;
          end
        endcase
      end
    end
    res.busy_res = frame_active;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0d ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic request_t random_request(input logic [1:0] command);
    request_t req;
    req.command = command;
    req.bank = 4'($urandom_range(0, 15));
    req.sub_address = 3'($urandom_range(0, 7));
    req.write_data = 8'($urandom_range(0, 255));
    req.sdo = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Queue a start and the ticks that carry its frame through the done tick.
  // Stray commands on the following ticks exercise starts while busy.
  task automatic add_frame(input logic [1:0] command, input logic [3:0] bank,
                           input logic [2:0] sub_address, input logic [7:0] write_data,
                           input int sdo_mode, input int stray_odds);
    request_t req;
    req = random_request(command);
    req.bank = bank;
    req.sub_address = sub_address;
    req.write_data = write_data;
    if (sdo_mode != SDO_RANDOM) req.sdo = (sdo_mode == SDO_HIGH);
    pending_requests.push_back(req);
    repeat (3 * FRAME_BITS) begin
      req = random_request(CMD_TICK);
      if (stray_odds != 0 && $urandom_range(1, stray_odds) == 1) begin
        req.command = 2'($urandom_range(1, 3));
      end
      if (sdo_mode != SDO_RANDOM) req.sdo = (sdo_mode == SDO_HIGH);
      pending_requests.push_back(req);
    end
  endtask

  // Request driver: holds a stalled request and idles in random bursts.
  always @(negedge clk) begin
    quiet_tail <= (pending_requests.size() < TAIL_ITEMS);
    if (rst) begin
      request_valid <= 1'b0;
    end else if (request_valid && !request_taken) begin
      request_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      request_valid <= 1'b0;
    end else if (pending_requests.size() == 0) begin
      request_valid <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 11);
      request_valid <= 1'b0;
    end else begin
      request <= pending_requests.pop_front();
      request_valid <= 1'b1;
    end
  end

  // Result side stall in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 11);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Monitor: predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin
    request_taken <= !rst && request_valid && !request_stall;
    if (!rst && request_valid && !request_stall) begin
      expected_pins.push_back(step_frame(request));
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_pins.size() == 0) begin
        $display("%0d ns: result with none expected, expected nothing, actual %p",
                 $time, result);
        error_count++;
      end else begin
        result_t want;
        want = expected_pins.pop_front();
        check_field("cs", 8'(want.cs), 8'(result.cs));
        check_field("sck", 8'(want.sck), 8'(result.sck));
        check_field("sdi", 8'(want.sdi), 8'(result.sdi));
        check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(result.done_res));
        check_field("read_data", want.read_data, result.read_data);
        check_field("rejected", 8'(want.rejected), 8'(result.rejected));
      end
    end
  end

  initial begin
    request_t req;
    // Ticks while idle, including the unused command value, at both field extremes.
    pending_requests.push_back('0);
    req = '1;
    req.command = CMD_SPARE;
    pending_requests.push_back(req);
    req.command = CMD_TICK;
    pending_requests.push_back(req);
    // All-ones write with dense starts while busy, then a read right after done.
    add_frame(CMD_WRITE, 4'hf, 3'h7, 8'hff, SDO_HIGH, 3);
    add_frame(CMD_READ, 4'hf, 3'h7, 8'hff, SDO_HIGH, 3);
    add_frame(CMD_READ, 4'h0, 3'h0, 8'h00, SDO_LOW, 0);
    add_frame(CMD_WRITE, 4'h0, 3'h0, 8'h00, SDO_RANDOM, 0);
    add_frame(CMD_READ, 4'h5, 3'h2, 8'ha5, SDO_RANDOM, 0);

    // Mostly complete frames with random content, some random noise between them.
    while (pending_requests.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 20)) begin
          pending_requests.push_back(random_request(2'($urandom_range(0, 3))));
        end
      end else begin
        repeat ($urandom_range(0, 3)) pending_requests.push_back(random_request(CMD_TICK));
        add_frame($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 4'($urandom_range(0, 15)),
                  3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), SDO_RANDOM,
                  $urandom_range(0, 1) ? 12 : 0);
      end
    end

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || request_valid || expected_pins.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
